// ===== rtl/attc_pkg.sv =====
// Shared constants and helpers for the ANSI text terminal controller.
`default_nettype none
package attc_pkg;
  localparam int unsigned MaxValues = 8;
  localparam logic [7:0] ColumnsReset = 8'd80;
  localparam logic [7:0] RowsReset = 8'd25;
  localparam logic [0:0] RegColumns = 1'b0;
  localparam logic [0:0] RegRows = 1'b1;
  localparam logic [7:0] ChEsc = 8'h1B;
  localparam logic [7:0] ChBs = 8'h08;
  localparam logic [7:0] ChLf = 8'h0A;
  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [2:0] EraseNone = 3'd0;
  localparam logic [2:0] EraseScreen = 3'd1;
  localparam logic [2:0] EraseToEnd = 3'd2;
  localparam logic [2:0] EraseLineEnd = 3'd3;
  localparam logic [2:0] EraseLineStart = 3'd4;
  localparam logic [2:0] EraseLine = 3'd5;

  // Map ANSI color order onto the attribute color order.
  function automatic logic [2:0] color_map(input logic [2:0] c);
    case (c)
      3'd0: color_map = 3'd0;
      3'd1: color_map = 3'd4;
      3'd2: color_map = 3'd2;
      3'd3: color_map = 3'd6;
      3'd4: color_map = 3'd1;
      3'd5: color_map = 3'd5;
      3'd6: color_map = 3'd3;
      default: color_map = 3'd7;
    endcase
  endfunction
endpackage
`default_nettype wire

// ===== rtl/ansi_text_terminal_controller.sv =====
// ANSI terminal byte parser: each input transfer passes the clip and decode states before the
// result is valid; a CSI digit also takes one pass through the shared multiply-by-ten and
// saturate unit, and SGR 'm' applies one stored parameter per cycle (at least one pass).
// The output transfer, which waits while the output stalls, and the return to idle follow
// each result; a new byte is taken only after them. Not ready while busy.
// Reset: asynchronous, active low; window 80x25, attribute 0x07, cursor 0,0,
// parser normal, all parameters zero.
`default_nettype none
module ansi_text_terminal_controller #(
  parameter int unsigned MAX_VALUES = attc_pkg::MaxValues
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [0:0] cfg_index_i,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] byte_in_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            put_valid_o,
  output logic [7:0]      cell_col_o,
  output logic [7:0]      cell_row_o,
  output logic [7:0]      glyph_o,
  output logic [7:0]      attr_o,
  output logic            scroll_up_o,
  output logic [2:0]      erase_kind_o,
  output logic [7:0]      cursor_col_o,
  output logic [7:0]      cursor_row_o
);
  import attc_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_VALUES);
  localparam int unsigned CntW = $clog2(MAX_VALUES + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_VALUES);

  typedef enum logic [1:0] {
    PM_NORMAL = 2'd0, PM_ESC = 2'd1, PM_CSI = 2'd2
  } pmode_e;
  typedef enum logic [2:0] {
    S_IDLE, S_CLIP, S_DECODE, S_MAC, S_SGR, S_DONE
  } state_e;

  state_e state_q;
  pmode_e pmode_q;
  logic [7:0] cols_q, rows_q;
  logic [15:0] vals_q [MAX_VALUES];
  logic [CntW-1:0] vcnt_q;
  logic [CntW-1:0] sgr_i_q;
  logic bold_q;
  logic [3:0] fg_q, bg_q;
  logic [7:0] crow_q, ccol_q;
  logic [7:0] c_q;
  logic [IdxW-1:0] k_q;

  logic [7:0] w, h;
  assign w = (cols_q == 8'd0) ? 8'd1 : cols_q;
  assign h = (rows_q == 8'd0) ? 8'd1 : rows_q;

  // shared multiply-accumulate with saturation
  logic [20:0] mac;
  logic [15:0] mac_sat;
  assign mac = {vals_q[k_q], 3'b000} + {2'b00, vals_q[k_q], 1'b0}
             + {13'd0, c_q - 8'h30};
  assign mac_sat = (mac > 21'd65535) ? 16'hFFFF : mac[15:0];

  // first two parameters for final bytes
  logic [15:0] n0, m0, n1, m1;
  assign n0 = (vcnt_q > 0) ? vals_q[0] : 16'd0;
  assign m0 = (vcnt_q > 1) ? vals_q[1] : 16'd0;
  assign n1 = (n0 == 16'd0) ? 16'd1 : n0;
  assign m1 = (m0 == 16'd0) ? 16'd1 : m0;

  // SGR step on one parameter
  logic [15:0] p;
  logic [3:0] sfg, sbg;
  logic sbold;
  assign p = (vcnt_q == '0) ? 16'd0 : vals_q[sgr_i_q[IdxW-1:0]];
  always_comb begin
    sfg = fg_q; sbg = bg_q; sbold = bold_q;
    if (p == 16'd0) begin
      sbold = 1'b0; sfg = 4'd7; sbg = 4'd0;
    end else if (p == 16'd1) begin
      sbold = 1'b1; sfg = fg_q | 4'd8;
    end else if (p == 16'd2 || p == 16'd22) begin
      sbold = 1'b0; sfg = fg_q & 4'd7;
    end else if (p == 16'd7) begin
      sfg = bg_q; sbg = fg_q;
    end else if (p >= 16'd30 && p <= 16'd37) begin
      sfg = {bold_q, color_map(3'(p - 16'd30))};
    end else if (p == 16'd39) begin
      sfg = {bold_q, 3'd7};
    end else if (p >= 16'd40 && p <= 16'd47) begin
      sbg = {1'b0, color_map(3'(p - 16'd40))};
    end else if (p == 16'd49) begin
      sbg = 4'd0;
    end else if (p >= 16'd90 && p <= 16'd97) begin
      sfg = {1'b1, color_map(3'(p - 16'd90))};
    end else if (p >= 16'd100 && p <= 16'd107) begin
      sbg = {1'b1, color_map(3'(p - 16'd100))};
    end
  end

  // wide helpers for cursor arithmetic
  logic [16:0] rsum, csum;
  assign rsum = {9'd0, crow_q} + {1'b0, n1};
  assign csum = {9'd0, ccol_q} + {1'b0, n1};
  logic [8:0] tab_nx;
  assign tab_nx = ({1'b0, ccol_q} + 9'd8) & 9'h1F8;

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; pmode_q <= PM_NORMAL;
      cols_q <= ColumnsReset; rows_q <= RowsReset;
      for (int i = 0; i < MAX_VALUES; i++) vals_q[i] <= 16'd0;
      vcnt_q <= '0; sgr_i_q <= '0; bold_q <= 1'b0;
      fg_q <= 4'd7; bg_q <= 4'd0; crow_q <= 8'd0; ccol_q <= 8'd0;
      out_valid_o <= 1'b0; put_valid_o <= 1'b0; cell_col_o <= 8'd0;
      cell_row_o <= 8'd0; glyph_o <= 8'd0; scroll_up_o <= 1'b0;
      erase_kind_o <= EraseNone; c_q <= 8'd0; k_q <= '0;
    end else begin
      // configuration writes
      if (cfg_we_i) begin
        if (cfg_index_i == RegColumns) cols_q <= cfg_data_i;
        else rows_q <= cfg_data_i;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            c_q <= byte_in_i;
            put_valid_o <= 1'b0; cell_col_o <= 8'd0; cell_row_o <= 8'd0;
            glyph_o <= 8'd0; scroll_up_o <= 1'b0; erase_kind_o <= EraseNone;
            state_q <= S_CLIP;
          end
        end
        S_CLIP: begin
          // clip cursor to the window
          if (ccol_q >= w) ccol_q <= w - 8'd1;
          if (crow_q >= h) crow_q <= h - 8'd1;
          state_q <= S_DECODE;
        end
        S_DECODE: begin
          state_q <= S_DONE;
          if (pmode_q == PM_CSI) begin
            if (c_q >= 8'h30 && c_q <= 8'h39) begin
              if (vcnt_q == '0) begin
                vcnt_q <= CntW'(1); k_q <= '0;
              end else begin
                k_q <= IdxW'(vcnt_q - CntW'(1));
              end
              state_q <= S_MAC;
            end else if (c_q == 8'h3B) begin
              if (vcnt_q < CntMax) vcnt_q <= vcnt_q + CntW'(1);
            end else if (c_q == 8'h3F) begin
              pmode_q <= PM_CSI;
            end else if (c_q >= 8'h40 && c_q <= 8'h7E) begin
              pmode_q <= PM_NORMAL;
              case (c_q)
                8'h6D: begin
                  sgr_i_q <= '0; state_q <= S_SGR;
                end
                8'h4A: begin
                  if (n0 == 16'd2 || n0 == 16'd3) begin
                    erase_kind_o <= EraseScreen; crow_q <= 8'd0; ccol_q <= 8'd0;
                  end else if (n0 == 16'd0) erase_kind_o <= EraseToEnd;
                end
                8'h4B: begin
                  if (n0 == 16'd0) erase_kind_o <= EraseLineEnd;
                  else if (n0 == 16'd1) erase_kind_o <= EraseLineStart;
                  else if (n0 == 16'd2) erase_kind_o <= EraseLine;
                end
                8'h48, 8'h66: begin
                  crow_q <= ((n1 - 16'd1) >= {8'd0, h}) ? h - 8'd1 : 8'(n1 - 16'd1);
                  ccol_q <= ((m1 - 16'd1) >= {8'd0, w}) ? w - 8'd1 : 8'(m1 - 16'd1);
                end
                8'h41: crow_q <= (n1 > {8'd0, crow_q}) ? 8'd0 : 8'({8'd0, crow_q} - n1);
                8'h42: crow_q <= (rsum >= {9'd0, h}) ? h - 8'd1 : rsum[7:0];
                8'h43: ccol_q <= (csum >= {9'd0, w}) ? w - 8'd1 : csum[7:0];
                8'h44: ccol_q <= (n1 > {8'd0, ccol_q}) ? 8'd0 : 8'({8'd0, ccol_q} - n1);
                8'h47: ccol_q <= ((n1 - 16'd1) >= {8'd0, w}) ? w - 8'd1 : 8'(n1 - 16'd1);
                default: ;
              endcase
            end else begin
              pmode_q <= PM_NORMAL;
            end
          end else if (pmode_q == PM_ESC && c_q == 8'h5B) begin
            pmode_q <= PM_CSI; vcnt_q <= '0;
            for (int i = 0; i < MAX_VALUES; i++) vals_q[i] <= 16'd0;
          end else begin
            // normal byte handling
            pmode_q <= PM_NORMAL;
            if (c_q == ChEsc) begin
              pmode_q <= PM_ESC;
            end else if (c_q == ChBs) begin
              put_valid_o <= 1'b1; glyph_o <= ChSpace;
              if (ccol_q > 8'd0) begin
                ccol_q <= ccol_q - 8'd1; cell_col_o <= ccol_q - 8'd1;
                cell_row_o <= crow_q;
              end else if (crow_q > 8'd0) begin
                crow_q <= crow_q - 8'd1; ccol_q <= w - 8'd1;
                cell_col_o <= w - 8'd1; cell_row_o <= crow_q - 8'd1;
              end else begin
                cell_col_o <= 8'd0; cell_row_o <= 8'd0;
              end
            end else if (c_q == ChLf) begin
              ccol_q <= 8'd0;
              if ({1'b0, crow_q} + 9'd1 >= {1'b0, h}) begin
                scroll_up_o <= 1'b1; crow_q <= h - 8'd1;
              end else crow_q <= crow_q + 8'd1;
            end else if (c_q == ChCr) begin
              ccol_q <= 8'd0;
            end else if (c_q == ChTab) begin
              ccol_q <= (tab_nx >= {1'b0, w}) ? w - 8'd1 : tab_nx[7:0];
            end else begin
              put_valid_o <= 1'b1; glyph_o <= c_q;
              cell_col_o <= ccol_q; cell_row_o <= crow_q;
              if ({1'b0, ccol_q} + 9'd1 >= {1'b0, w}) begin
                ccol_q <= 8'd0;
                if ({1'b0, crow_q} + 9'd1 >= {1'b0, h}) begin
                  scroll_up_o <= 1'b1; crow_q <= h - 8'd1;
                end else crow_q <= crow_q + 8'd1;
              end else ccol_q <= ccol_q + 8'd1;
            end
          end
        end
        S_MAC: begin
          // accumulate one decimal digit
          vals_q[k_q] <= mac_sat;
          state_q <= S_DONE;
        end
        S_SGR: begin
          // apply one stored parameter per cycle
          fg_q <= sfg; bg_q <= sbg; bold_q <= sbold;
          if (vcnt_q == '0 || sgr_i_q + CntW'(1) >= vcnt_q) state_q <= S_DONE;
          else sgr_i_q <= sgr_i_q + CntW'(1);
        end
        S_DONE: begin
          if (!out_valid_o) out_valid_o <= 1'b1;
          else if (!out_stall_i) begin
            out_valid_o <= 1'b0; state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign attr_o = {bg_q, fg_q};
  assign cursor_col_o = ccol_q;
  assign cursor_row_o = crow_q;

  // result only while finishing an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> state_q == S_DONE) else $error("result outside done");
  // a written cell lies in the window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && put_valid_o) |-> (cell_col_o < w && cell_row_o < h))
    else $error("cell outside window");
  // value count never exceeds capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vcnt_q <= CntMax) else $error("value count overflow");
endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the ANSI text terminal controller.
`default_nettype none
module tb;
  import attc_pkg::*;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [0:0] cfg_index_i = RegColumns;
  logic [7:0] cfg_data_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] byte_in_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       put_valid_o, scroll_up_o;
  logic [7:0] cell_col_o, cell_row_o, glyph_o, attr_o, cursor_col_o, cursor_row_o;
  logic [2:0] erase_kind_o;

  typedef struct packed {
    logic       put;
    logic [7:0] ccol;
    logic [7:0] crow;
    logic [7:0] glyph;
    logic [7:0] attr;
    logic       scroll;
    logic [2:0] erase;
    logic [7:0] kcol;
    logic [7:0] krow;
  } term_out_t;

  typedef enum logic [1:0] {PmNormal = 2'd0, PmEsc = 2'd1, PmCsi = 2'd2} pmode_e;

  ansi_text_terminal_controller u_dut (.*);

  always #1 clk_i = ~clk_i;

  // Predictor state
  logic [7:0]  win_cols, win_rows;
  pmode_e      pm;
  logic [15:0] params [MaxValues];
  int unsigned nparams;
  logic        bold;
  logic [3:0]  fg, bg;
  int unsigned crow, ccol;

  term_out_t   pending_q[$];
  int          errors = 0;

  function automatic logic [2:0] ansi_to_attr(input int unsigned c);
    logic [2:0] lut [8] = '{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7};
    return lut[c];
  endfunction

  // Apply one SGR value
  function automatic void apply_sgr(input int unsigned p);
    logic [3:0] t;
    if (p == 0) begin
      bold = 1'b0; fg = 4'd7; bg = 4'd0;
    end else if (p == 1) begin
      bold = 1'b1; fg = fg | 4'd8;
    end else if (p == 2 || p == 22) begin
      bold = 1'b0; fg = fg & 4'd7;
    end else if (p == 7) begin
      t = fg; fg = bg; bg = t;
    end else if (p >= 30 && p <= 37) begin
      fg = {bold, ansi_to_attr(p - 30)};
    end else if (p == 39) begin
      fg = bold ? 4'd15 : 4'd7;
    end else if (p >= 40 && p <= 47) begin
      bg = {1'b0, ansi_to_attr(p - 40)};
    end else if (p == 49) begin
      bg = 4'd0;
    end else if (p >= 90 && p <= 97) begin
      fg = {1'b1, ansi_to_attr(p - 90)};
    end else if (p >= 100 && p <= 107) begin
      bg = {1'b1, ansi_to_attr(p - 100)};
    end
  endfunction

  task automatic predictor_reset();
    win_cols = ColumnsReset; win_rows = RowsReset;
    pm = PmNormal; nparams = 0; bold = 1'b0; fg = 4'd7; bg = 4'd0; crow = 0; ccol = 0;
    foreach (params[i]) params[i] = '0;
  endtask

  // Run a CSI final byte, return erase kind
  function automatic logic [2:0] run_final(input logic [7:0] cmd, input int unsigned w,
                                           input int unsigned h);
    int unsigned n, m;
    logic [2:0] kind;
    n = nparams > 0 ? params[0] : 0;
    m = nparams > 1 ? params[1] : 0;
    kind = EraseNone;
    case (cmd)
      "m": begin
        if (nparams == 0) apply_sgr(0);
        for (int i = 0; i < nparams && i < MaxValues; i++) apply_sgr(params[i]);
      end
      "J": begin
        if (n == 2 || n == 3) begin
          kind = EraseScreen; crow = 0; ccol = 0;
        end else if (n == 0) kind = EraseToEnd;
      end
      "K": begin
        if (n == 0) kind = EraseLineEnd;
        else if (n == 1) kind = EraseLineStart;
        else if (n == 2) kind = EraseLine;
      end
      "H", "f": begin
        if (n == 0) n = 1;
        if (m == 0) m = 1;
        crow = (n - 1 >= h) ? h - 1 : n - 1;
        ccol = (m - 1 >= w) ? w - 1 : m - 1;
      end
      "A": begin
        if (n == 0) n = 1;
        crow = n > crow ? 0 : crow - n;
      end
      "B": begin
        if (n == 0) n = 1;
        crow = crow + n; if (crow >= h) crow = h - 1;
      end
      "C": begin
        if (n == 0) n = 1;
        ccol = ccol + n; if (ccol >= w) ccol = w - 1;
      end
      "D": begin
        if (n == 0) n = 1;
        ccol = n > ccol ? 0 : ccol - n;
      end
      "G": begin
        if (n == 0) n = 1;
        ccol = (n - 1 >= w) ? w - 1 : n - 1;
      end
      default: ;
    endcase
    return kind;
  endfunction

  // Predict the result of one byte and advance the predictor
  function automatic term_out_t predict_byte(input logic [7:0] c);
    term_out_t r;
    int unsigned w, h, k, v, nx;
    bit normal;
    r = '0; normal = 1;
    w = (win_cols == 0) ? 1 : win_cols;
    h = (win_rows == 0) ? 1 : win_rows;
    if (ccol >= w) ccol = w - 1;
    if (crow >= h) crow = h - 1;
    if (pm == PmEsc) begin
      if (c == "[") begin
        pm = PmCsi; nparams = 0; normal = 0;
        foreach (params[i]) params[i] = '0;
      end else pm = PmNormal;
    end else if (pm == PmCsi) begin
      normal = 0;
      if (c >= "0" && c <= "9") begin
        if (nparams == 0) nparams = 1;
        k = nparams - 1;
        v = params[k] * 10 + (c - "0");
        params[k] = v > 65535 ? 16'hFFFF : v[15:0];
      end else if (c == ";") begin
        if (nparams < MaxValues) nparams++;
      end else if (c == "?") begin
      end else if (c >= 8'h40 && c <= 8'h7E) begin
        r.erase = run_final(c, w, h); pm = PmNormal;
      end else pm = PmNormal;
    end else pm = PmNormal;

    if (normal) begin
      if (c == ChEsc) pm = PmEsc;
      else if (c == ChBs) begin
        if (ccol > 0) ccol--;
        else if (crow > 0) begin
          crow--; ccol = w - 1;
        end
        r.put = 1; r.ccol = 8'(ccol); r.crow = 8'(crow); r.glyph = ChSpace;
      end else if (c == ChLf) begin
        ccol = 0;
        if (crow + 1 >= h) begin
          r.scroll = 1; crow = h - 1;
        end else crow++;
      end else if (c == ChCr) ccol = 0;
      else if (c == ChTab) begin
        nx = (ccol + 8) & ~32'd7;
        if (nx >= w) nx = w - 1;
        ccol = nx;
      end else begin
        r.put = 1; r.ccol = 8'(ccol); r.crow = 8'(crow); r.glyph = c;
        if (ccol + 1 >= w) begin
          ccol = 0;
          if (crow + 1 >= h) begin
            r.scroll = 1; crow = h - 1;
          end else crow++;
        end else ccol++;
      end
    end
    r.attr = {bg, fg};
    r.kcol = 8'(ccol); r.krow = 8'(crow);
    return r;
  endfunction

  // Drive one byte transfer and wait until the block takes it
  task automatic send_byte(input logic [7:0] b);
    pending_q.push_back(predict_byte(b));
    in_valid_i <= 1'b1;
    byte_in_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic sender_gap(input int unsigned cycles);
    if (cycles > 0) begin
      in_valid_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Let the block drain before touching registers
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [7:0] val);
    cfg_we_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegColumns) win_cols = val;
    else win_rows = val;
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Send one random burst: a byte, a control byte or a mostly well-formed escape sequence
  task automatic random_burst();
    int unsigned sel, n;
    string finals;
    finals = "mHfABCDGJKxm";
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      send_byte(8'($urandom_range(0, 255)));
    end else if (sel < 5) begin
      send_byte(8'(32'h20 + $urandom_range(0, 94)));
    end else if (sel < 6) begin
      case ($urandom_range(0, 4))
        0: send_byte(ChBs);
        1: send_byte(ChLf);
        2: send_byte(ChCr);
        3: send_byte(ChTab);
        default: send_byte(8'h7F);
      endcase
    end else begin
      send_byte(ChEsc);
      if ($urandom_range(0, 9) == 0) begin
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        send_byte("[");
        n = $urandom_range(0, 10);
        for (int i = 0; i < n; i++) begin
          case ($urandom_range(0, 9))
            0: send_byte(";");
            1: send_byte("?");
            2: send_str($sformatf("%0d", $urandom_range(0, 99999)));
            3: send_str($sformatf("%0d;", 90 + $urandom_range(0, 17)));
            default: send_str($sformatf("%0d;", $urandom_range(0, 49)));
          endcase
        end
        if ($urandom_range(0, 19) == 0) send_byte(8'($urandom_range(0, 255)));
        else send_byte(finals[$urandom_range(0, finals.len() - 1)]);
      end
    end
  endtask

  // Directed table: byte, typed expectation valid flag, typed expectation
  typedef struct {
    logic [7:0] b;
    bit         typed;
    term_out_t  want;
  } dir_row_t;

  dir_row_t dir_tbl[$];

  task automatic run_directed();
    string seqs[$];
    seqs = '{"\033[;5H", "\033[1;31;44m", "\033[7m", "\033[m", "\033[99999;300H",
             "\033[2J", "\033[K", "\033[1K", "\033[2K", "\033[0J", "\033[1J",
             "\033[5A\033[3B\033[4C\033[2D\033[9G", "\033[?25h", "\033[1;2;3;4;5;6;7;8;9;10m",
             "\033[12\033x", "\033Q", "\033[97;107;39;49;22m", "\033[200;200f"};
    // Reset state: a printable at 0,0 and a backspace at column 1
    dir_tbl.push_back('{8'h41, 1'b1, '{1'b1, 8'd0, 8'd0, 8'h41, 8'h07, 1'b0, EraseNone,
                                       8'd1, 8'd0}});
    dir_tbl.push_back('{ChBs, 1'b1, '{1'b1, 8'd0, 8'd0, ChSpace, 8'h07, 1'b0, EraseNone,
                                     8'd0, 8'd0}});
    dir_tbl.push_back('{ChBs, 1'b1, '{1'b1, 8'd0, 8'd0, ChSpace, 8'h07, 1'b0, EraseNone,
                                     8'd0, 8'd0}});
    dir_tbl.push_back('{8'hFF, 1'b0, '0});
    dir_tbl.push_back('{8'h00, 1'b0, '0});
    dir_tbl.push_back('{ChTab, 1'b0, '0});
    dir_tbl.push_back('{ChLf, 1'b0, '0});
    dir_tbl.push_back('{ChCr, 1'b0, '0});
    foreach (dir_tbl[i]) begin
      term_out_t p;
      p = predict_byte(dir_tbl[i].b);
      pending_q.push_back(dir_tbl[i].typed ? dir_tbl[i].want : p);
      in_valid_i <= 1'b1; byte_in_i <= dir_tbl[i].b;
      do @(posedge clk_i); while (in_stall_o);
    end
    foreach (seqs[i]) send_str(seqs[i]);
  endtask

  // Result checker
  always @(posedge clk_i) begin
    term_out_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{put_valid_o, cell_col_o, cell_row_o, glyph_o, attr_o, scroll_up_o,
              erase_kind_o, cursor_col_o, cursor_row_o};
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (got.put !== want.put) begin
          $display("%0t: put_valid exp %h got %h", $time, want.put, got.put); errors++;
        end
        if (got.ccol !== want.ccol) begin
          $display("%0t: cell_col exp %h got %h", $time, want.ccol, got.ccol); errors++;
        end
        if (got.crow !== want.crow) begin
          $display("%0t: cell_row exp %h got %h", $time, want.crow, got.crow); errors++;
        end
        if (got.glyph !== want.glyph) begin
          $display("%0t: glyph exp %h got %h", $time, want.glyph, got.glyph); errors++;
        end
        if (got.attr !== want.attr) begin
          $display("%0t: attr exp %h got %h", $time, want.attr, got.attr); errors++;
        end
        if (got.scroll !== want.scroll) begin
          $display("%0t: scroll_up exp %h got %h", $time, want.scroll, got.scroll); errors++;
        end
        if (got.erase !== want.erase) begin
          $display("%0t: erase_kind exp %h got %h", $time, want.erase, got.erase); errors++;
        end
        if (got.kcol !== want.kcol) begin
          $display("%0t: cursor_col exp %h got %h", $time, want.kcol, got.kcol); errors++;
        end
        if (got.krow !== want.krow) begin
          $display("%0t: cursor_row exp %h got %h", $time, want.krow, got.krow); errors++;
        end
      end
    end
  end

  // Receiver stall pattern: runs of free flow and random stalls
  always @(posedge clk_i) begin
    int unsigned phase;
    phase = 32'(($time / 200) % 4);
    if (phase == 0) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(0, 3) < phase);
  end

  // Window sizes per phase, extremes included
  logic [7:0] phase_cols [6] = '{8'd80, 8'd1, 8'd255, 8'd0, 8'd7, 8'd20};
  logic [7:0] phase_rows [6] = '{8'd25, 8'd255, 8'd1, 8'd0, 8'd3, 8'd254};

  initial begin
    predictor_reset();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    wait_idle();
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(RegColumns, phase_cols[ph]);
      write_reg(RegRows, phase_rows[ph]);
      for (int b = 0; b < 50; b++) begin
        random_burst();
        if ($urandom_range(0, 2) == 0) sender_gap($urandom_range(1, 12));
        if (b == 25) wait_idle();
      end
      wait_idle();
    end
    wait_idle();
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
`default_nettype wire
